FILE: sv/hermite_polyline_smoother_defines.svh
// Assertion macros used by the smoother top level.
`ifndef HERMITE_POLYLINE_SMOOTHER_DEFINES_SVH
`define HERMITE_POLYLINE_SMOOTHER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define HPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hps check failed");
// Checked property, also evaluated during reset.
`define HPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hps check failed");
`else
`define HPS_ASSERT(lbl, clk, rstn, prop)
`define HPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: sv/hps_pkg.sv
// Types and constants of the Hermite polyline smoother.
`default_nettype none

package hps_pkg;

  localparam int COORD_W = 16;   // input coordinate
  localparam int TAN_W   = 17;   // tangent (difference of two coordinates)
  localparam int OUT_W   = 18;   // curve coordinate
  localparam int W_W     = 18;   // basis weight, Q2.16
  localparam int PROD_W  = 35;   // weight times tangent
  localparam int SUM_W   = 36;
  localparam int ACC_W   = 37;

  // segment queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // one curve segment: end points, tangents, and the run end mark
  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [TAN_W-1:0]   tax;
    logic signed [TAN_W-1:0]   tay;
    logic signed [TAN_W-1:0]   tbx;
    logic signed [TAN_W-1:0]   tby;
    logic                      last;
  } seg_t;

  // segments pushed by the front in one cycle (zero, one or two)
  typedef struct packed {
    logic [1:0] n;
    seg_t       s0;
    seg_t       s1;
  } push_t;

  // queue status toward the front
  typedef struct packed {
    logic [QCNT_W-1:0] cnt;
  } qstat_t;

  // queue head toward the back
  typedef struct packed {
    logic valid;
    seg_t seg;
  } qhead_t;

endpackage

`default_nettype wire

FILE: sv/hps_if.sv
// Handshake channels of the smoother: input points and curve samples.
`default_nettype none

interface hps_point_if import hps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

interface hps_curve_if import hps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] curve_x;
  logic signed [OUT_W-1:0] curve_y;
  logic                    run_end;

  modport source (output valid, curve_x, curve_y, run_end, input ready);
  modport sink   (input valid, curve_x, curve_y, run_end, output ready);
endinterface

`default_nettype wire

FILE: sv/hps_front.sv
// Front end: point history, segment classification and tangent setup.
`default_nettype none

module hps_front import hps_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hps_point_if.sink   in_pt,
  input  wire qstat_t q_stat,
  output push_t       push
);

  logic signed [COORD_W-1:0] hx_r [3];
  logic signed [COORD_W-1:0] hy_r [3];
  logic [1:0]                ps_r;
  logic                      acc;
  logic                      fin;
  logic signed [COORD_W-1:0] nx, ny;
  seg_t                      mid_seg, close_seg, pair_seg;
  logic [1:0]                n_seg;

  function automatic logic signed [TAN_W-1:0] tdiff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    tdiff = TAN_W'(a) - TAN_W'(b);
  endfunction

  // room for two segments lets a closing point always go through
  assign in_pt.ready = (q_stat.cnt <= QCNT_W'(QDEPTH - 2));
  assign acc = in_pt.valid && in_pt.ready;
  assign fin = in_pt.final_point;
  assign nx  = in_pt.point_x;
  assign ny  = in_pt.point_y;

  // candidate segments
  always_comb begin
    // segment ending at the newest stored point
    mid_seg.ax   = hx_r[1];
    mid_seg.ay   = hy_r[1];
    mid_seg.bx   = hx_r[2];
    mid_seg.by   = hy_r[2];
    mid_seg.tax  = (ps_r == 2'd2) ? tdiff(hx_r[2], hx_r[1]) : tdiff(hx_r[2], hx_r[0]);
    mid_seg.tay  = (ps_r == 2'd2) ? tdiff(hy_r[2], hy_r[1]) : tdiff(hy_r[2], hy_r[0]);
    mid_seg.tbx  = tdiff(nx, hx_r[1]);
    mid_seg.tby  = tdiff(ny, hy_r[1]);
    mid_seg.last = !fin;
    // closing segment to the final point
    close_seg.ax   = hx_r[2];
    close_seg.ay   = hy_r[2];
    close_seg.bx   = nx;
    close_seg.by   = ny;
    close_seg.tax  = tdiff(nx, hx_r[1]);
    close_seg.tay  = tdiff(ny, hy_r[1]);
    close_seg.tbx  = tdiff(nx, hx_r[2]);
    close_seg.tby  = tdiff(ny, hy_r[2]);
    close_seg.last = 1'b1;
    // two-point polyline: both tangents are the chord
    pair_seg.ax   = hx_r[2];
    pair_seg.ay   = hy_r[2];
    pair_seg.bx   = nx;
    pair_seg.by   = ny;
    pair_seg.tax  = tdiff(nx, hx_r[2]);
    pair_seg.tay  = tdiff(ny, hy_r[2]);
    pair_seg.tbx  = pair_seg.tax;
    pair_seg.tby  = pair_seg.tay;
    pair_seg.last = 1'b1;
  end

  // classification by points seen so far
  always_comb begin
    push.s0 = mid_seg;
    push.s1 = close_seg;
    n_seg   = 2'd0;
    case (ps_r)
      2'd0: n_seg = 2'd0;
      2'd1: begin
        push.s0 = pair_seg;
        n_seg   = fin ? 2'd1 : 2'd0;
      end
      2'd2, 2'd3: n_seg = fin ? 2'd2 : 2'd1;
      default: n_seg = 2'd0;
    endcase
    push.n = acc ? n_seg : 2'd0;
  end

  // point history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        hx_r[i] <= '0;
        hy_r[i] <= '0;
      end
    end else if (acc) begin
      if (fin) begin
        ps_r <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          hx_r[i] <= '0;
          hy_r[i] <= '0;
        end
      end else begin
        hx_r[0] <= hx_r[1];
        hy_r[0] <= hy_r[1];
        hx_r[1] <= hx_r[2];
        hy_r[1] <= hy_r[2];
        hx_r[2] <= nx;
        hy_r[2] <= ny;
        if (ps_r != 2'd3) ps_r <= ps_r + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/hps_queue.sv
// Segment queue between front and back; takes up to two segments a cycle.
`default_nettype none

module hps_queue import hps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output qstat_t     q_stat,
  output qhead_t     q_head
);

  seg_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign q_stat.cnt   = cnt_r;
  assign q_head.valid = (cnt_r != '0);
  assign q_head.seg   = ent_r[rd_r];

  // entries
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) ent_r[wr_r] <= push.s0;
    if (push.n == 2'd2) ent_r[wr_r + QPTR_W'(1)] <= push.s1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + QPTR_W'(push.n);
      rd_r  <= rd_r + QPTR_W'(pop);
      cnt_r <= cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: sv/hps_back.sv
// Back end: sample sequencer and pipelined Hermite evaluation.
`default_nettype none

module hps_back import hps_pkg::*; #(
  parameter int SAMPLES = 20
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qhead_t q_head,
  output logic        pop,
  hps_curve_if.source out_cv
);

  localparam int TW = $clog2(SAMPLES);
  localparam logic [TW-1:0] T_LAST = TW'(SAMPLES - 1);

  // basis weight tables, Q2.16, rounded half away from zero
  logic signed [W_W-1:0] w1_tab [SAMPLES];
  logic signed [W_W-1:0] w2_tab [SAMPLES];
  logic signed [W_W-1:0] w3_tab [SAMPLES];
  logic signed [W_W-1:0] w4_tab [SAMPLES];

  for (genvar t = 0; t < SAMPLES; t++) begin : g_wt
    localparam longint N  = SAMPLES;
    localparam longint D  = N * N * N;
    localparam longint T  = t;
    localparam longint T2 = T * T;
    localparam longint T3 = T2 * T;
    localparam longint N1 = 2 * T3 - 3 * T2 * N + D;
    localparam longint N2 = -2 * T3 + 3 * T2 * N;
    localparam longint N3 = T3 - 2 * T2 * N + T * N * N;
    localparam longint N4 = T3 - T2 * N;
    localparam longint W1 = (N1 >= 0) ? (N1 * 65536 + D / 2) / D
                                      : -(((-N1) * 65536 + D / 2) / D);
    localparam longint W2 = (N2 >= 0) ? (N2 * 65536 + D / 2) / D
                                      : -(((-N2) * 65536 + D / 2) / D);
    localparam longint W3 = (N3 >= 0) ? (N3 * 65536 + D / 2) / D
                                      : -(((-N3) * 65536 + D / 2) / D);
    localparam longint W4 = (N4 >= 0) ? (N4 * 65536 + D / 2) / D
                                      : -(((-N4) * 65536 + D / 2) / D);
    assign w1_tab[t] = W_W'(W1);
    assign w2_tab[t] = W_W'(W2);
    assign w3_tab[t] = W_W'(W3);
    assign w4_tab[t] = W_W'(W4);
  end

  // round half away from zero to an integer, then saturate
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0]    biased;
    logic signed [ACC_W-17:0]   r;
    biased = a + (a[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768));
    r      = biased[ACC_W-1:16];
    if (r > (ACC_W-16)'(131071))       round_sat = OUT_W'(131071);
    else if (r < -(ACC_W-16)'(131072)) round_sat = OUT_W'(-131072);
    else                               round_sat = r[OUT_W-1:0];
  endfunction

  logic          adv;
  logic          issue;
  logic [TW-1:0] t_r;

  // stage 1: weights and operands
  logic                  v1_r, e1_r;
  logic signed [W_W-1:0] w1_r, w2_r, w3_r, w4_r;
  seg_t                  s1_r;
  // stage 2: products
  logic                     v2_r, e2_r;
  logic signed [PROD_W-1:0] px_r [4];
  logic signed [PROD_W-1:0] py_r [4];
  // stage 3: pair sums
  logic                    v3_r, e3_r;
  logic signed [SUM_W-1:0] sxa_r, sxb_r, sya_r, syb_r;
  // stage 4: full sums
  logic                    v4_r, e4_r;
  logic signed [ACC_W-1:0] ax_r, ay_r;
  // output register
  logic                    ov_r, oe_r;
  logic signed [OUT_W-1:0] ox_r, oy_r;

  // the whole pipeline moves unless the output item is held
  assign adv   = !ov_r || out_cv.ready;
  assign issue = q_head.valid && adv;
  assign pop   = issue && (t_r == T_LAST);

  assign out_cv.valid   = ov_r;
  assign out_cv.curve_x = ox_r;
  assign out_cv.curve_y = oy_r;
  assign out_cv.run_end = oe_r;

  // sample counter over one segment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0;
    end else if (issue) begin
      t_r <= (t_r == T_LAST) ? '0 : t_r + TW'(1);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      ov_r <= v4_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r <= w1_tab[t_r];
      w2_r <= w2_tab[t_r];
      w3_r <= w3_tab[t_r];
      w4_r <= w4_tab[t_r];
      s1_r <= q_head.seg;
      e1_r <= q_head.seg.last && (t_r == T_LAST);

      px_r[0] <= PROD_W'(w1_r) * PROD_W'(s1_r.ax);
      px_r[1] <= PROD_W'(w2_r) * PROD_W'(s1_r.bx);
      px_r[2] <= PROD_W'(w3_r) * PROD_W'(s1_r.tax);
      px_r[3] <= PROD_W'(w4_r) * PROD_W'(s1_r.tbx);
      py_r[0] <= PROD_W'(w1_r) * PROD_W'(s1_r.ay);
      py_r[1] <= PROD_W'(w2_r) * PROD_W'(s1_r.by);
      py_r[2] <= PROD_W'(w3_r) * PROD_W'(s1_r.tay);
      py_r[3] <= PROD_W'(w4_r) * PROD_W'(s1_r.tby);
      e2_r    <= e1_r;

      sxa_r <= SUM_W'(px_r[0]) + SUM_W'(px_r[1]);
      sxb_r <= SUM_W'(px_r[2]) + SUM_W'(px_r[3]);
      sya_r <= SUM_W'(py_r[0]) + SUM_W'(py_r[1]);
      syb_r <= SUM_W'(py_r[2]) + SUM_W'(py_r[3]);
      e3_r  <= e2_r;

      ax_r <= ACC_W'(sxa_r) + ACC_W'(sxb_r);
      ay_r <= ACC_W'(sya_r) + ACC_W'(syb_r);
      e4_r <= e3_r;

      ox_r <= round_sat(ax_r);
      oy_r <= round_sat(ay_r);
      oe_r <= e4_r;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hermite_polyline_smoother.sv
// Top level of the cubic Hermite polyline smoother.
//
// in_pt takes polyline points (point_x, point_y, final_point) by valid/ready.
// out_cv gives curve samples (curve_x, curve_y, run_end) by valid/ready.
// From the third point of a polyline on, each point yields SAMPLES samples of
// the segment between the two points before it; the final point also yields
// the closing segment, and a two-point polyline yields one chord segment.
// run_end marks the last sample caused by one input point.
// Throughput: one sample per cycle unless a waiting output item is held
// by out_cv.ready low. A point's first sample reaches out_cv through the
// queue and the registers for weights, multiply, two add stages, and round
// and saturate.
// A four-entry segment queue lets points keep arriving while samples drain;
// in_pt.ready drops when fewer than two entries are free.
// Reset (rst_n low, synchronous) empties the queue and pipeline and clears
// the stored points. While out_cv.ready is low and an output item is waiting,
// the pipeline holds still and the output item stays put.
`default_nettype none
`include "hermite_polyline_smoother_defines.svh"

module hermite_polyline_smoother import hps_pkg::*; #(
  parameter int SAMPLES = 20
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hps_point_if.sink   in_pt,
  hps_curve_if.source out_cv
);

  push_t  push;
  qstat_t q_stat;
  qhead_t q_head;
  logic   pop;

  hps_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (in_pt),
    .q_stat (q_stat),
    .push   (push)
  );

  hps_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .q_stat (q_stat),
    .q_head (q_head)
  );

  hps_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .pop    (pop),
    .out_cv (out_cv)
  );

  // checks
  `HPS_ASSERT(a_q_bound, clk, rst_n, q_stat.cnt <= QCNT_W'(QDEPTH))
  `HPS_ASSERT(a_accept_room, clk, rst_n, in_pt.valid && in_pt.ready |-> q_stat.cnt <= QCNT_W'(QDEPTH - 2))
  `HPS_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> q_head.valid)
  `HPS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_cv.valid)

endmodule

`default_nettype wire

FILE: verif/hermite_polyline_smoother_tb.sv
// Self-checking testbench for the Hermite polyline smoother: random and directed polylines.
`default_nettype none

module hermite_polyline_smoother_tb import hps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLES     = 20;
  localparam int RESET_CYC   = 8;
  localparam int RANDOM_PTS  = 180;
  localparam int CALM_PTS    = 30;     // tail of the run without idling
  localparam int HOLD_AFTER  = 400;    // samples taken before the long hold-off
  localparam int HOLD_CYC    = 300;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 600000;

  // one polyline point waiting to be sent
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      fin;
    logic                      drain_first;  // wait for all samples before sending
  } point_t;

  // one expected curve sample
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    run_end;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // locally held drive values, known from time zero
  logic                      pt_valid = 1'b0;
  logic signed [COORD_W-1:0] pt_x = '0;
  logic signed [COORD_W-1:0] pt_y = '0;
  logic                      pt_fin = 1'b0;
  logic                      cv_ready = 1'b0;

  hps_point_if pt_ch ();
  hps_curve_if cv_ch ();

  assign pt_ch.valid       = pt_valid;
  assign pt_ch.point_x     = pt_x;
  assign pt_ch.point_y     = pt_y;
  assign pt_ch.final_point = pt_fin;
  assign cv_ch.ready       = cv_ready;

  hermite_polyline_smoother #(.SAMPLES(SAMPLES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (pt_ch.sink),
    .out_cv (cv_ch.source)
  );

  always #6 clk = ~clk;

  point_t  point_q[$];   // points not yet offered
  sample_t curve_q[$];   // samples predicted but not yet seen
  longint  basis[0:SAMPLES-1][0:3];
  longint  hist_x[0:2];  // last three points, index 2 newest
  longint  hist_y[0:2];
  int      pts_seen = 0;
  int      mismatches = 0;
  int      samples_taken = 0;
  int      cycle_cnt = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // num*65536/den rounded to nearest, ties away from zero
  function automatic longint q16_div(longint num, longint den);
    if (num >= 0)
      return (num * 65536 + den / 2) / den;
    return -(((-num) * 65536 + den / 2) / den);
  endfunction

  // Q.16 sum to integer coordinate, rounded and clamped
  function automatic logic signed [OUT_W-1:0] to_coord(longint acc);
    longint r;
    if (acc >= 0)
      r = (acc + 32768) / 65536;
    else
      r = -(((-acc) + 32768) / 65536);
    if (r > 131071)
      r = 131071;
    if (r < -131072)
      r = -131072;
    return r[OUT_W-1:0];
  endfunction

  // queue the SAMPLES points of one Hermite segment
  task automatic emit_curve_segment(longint ax, longint ay, longint bx, longint by,
                                    longint tax, longint tay, longint tbx, longint tby);
    sample_t s;
    for (int t = 0; t < SAMPLES; t++) begin
      s.x = to_coord(basis[t][0] * ax + basis[t][1] * bx +
                     basis[t][2] * tax + basis[t][3] * tbx);
      s.y = to_coord(basis[t][0] * ay + basis[t][1] * by +
                     basis[t][2] * tay + basis[t][3] * tby);
      s.run_end = 1'b0;
      curve_q.push_back(s);
    end
  endtask

  // one accepted point: predict its samples and shift the history
  task automatic advance_polyline(logic signed [COORD_W-1:0] px,
                                  logic signed [COORD_W-1:0] py, logic fin);
    longint  nx;
    longint  ny;
    int      q_len;
    sample_t s;
    nx = px;
    ny = py;
    q_len = curve_q.size();
    if (pts_seen == 1) begin
      // two-point polyline: chord with equal tangents
      if (fin)
        emit_curve_segment(hist_x[2], hist_y[2], nx, ny,
                           nx - hist_x[2], ny - hist_y[2], nx - hist_x[2], ny - hist_y[2]);
    end else if (pts_seen >= 2) begin
      // first segment takes P1-P0 as start tangent, later ones P[i]-P[i-2]
      if (pts_seen == 2)
        emit_curve_segment(hist_x[1], hist_y[1], hist_x[2], hist_y[2],
                           hist_x[2] - hist_x[1], hist_y[2] - hist_y[1],
                           nx - hist_x[1], ny - hist_y[1]);
      else
        emit_curve_segment(hist_x[1], hist_y[1], hist_x[2], hist_y[2],
                           hist_x[2] - hist_x[0], hist_y[2] - hist_y[0],
                           nx - hist_x[1], ny - hist_y[1]);
      // closing segment
      if (fin)
        emit_curve_segment(hist_x[2], hist_y[2], nx, ny,
                           nx - hist_x[1], ny - hist_y[1], nx - hist_x[2], ny - hist_y[2]);
    end
    if (curve_q.size() > q_len) begin
      s = curve_q.pop_back();
      s.run_end = 1'b1;
      curve_q.push_back(s);
    end
    if (fin) begin
      for (int i = 0; i < 3; i++) begin
        hist_x[i] = 0;
        hist_y[i] = 0;
      end
      pts_seen = 0;
    end else begin
      hist_x[0] = hist_x[1]; hist_y[0] = hist_y[1];
      hist_x[1] = hist_x[2]; hist_y[1] = hist_y[2];
      hist_x[2] = nx;        hist_y[2] = ny;
      if (pts_seen < 3)
        pts_seen++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_point(int x, int y, bit fin, bit drain);
    point_t p;
    p.x = x[COORD_W-1:0];
    p.y = y[COORD_W-1:0];
    p.fin = fin;
    p.drain_first = drain;
    point_q.push_back(p);
  endtask

  // pick a coordinate: full range, walk from the previous one, or mostly an extreme
  function automatic int pick_coord(int style, int prev);
    int corner;
    case (style)
      0: return $urandom;
      1: return prev + $urandom_range(0, 4000) - 2000;
      default: begin
        corner = $urandom_range(0, 4);
        case (corner)
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 0;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued points, random gap bursts between items
  // ---------------------------------------------------------------------------
  int send_gap = 0;
  int send_mood = 0;
  int send_mood_left = 0;

  always @(posedge clk) begin
    point_t nxt;
    if (!rst_n) begin
      pt_valid <= 1'b0;
    end else begin
      if (pt_valid && pt_ch.ready) begin
        advance_polyline(pt_x, pt_y, pt_fin);
        if (send_mood_left == 0) begin
          send_mood = $urandom_range(0, 2);
          send_mood_left = $urandom_range(10, 40);
        end else begin
          send_mood_left--;
        end
        if (point_q.size() > CALM_PTS && send_mood != 0 &&
            $urandom_range(0, 4) < send_mood * 2)
          send_gap = $urandom_range(1, 10);
      end
      if (!pt_valid || pt_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pt_valid <= 1'b0;
        end else if (point_q.size() == 0 ||
                     (point_q[0].drain_first && curve_q.size() != 0)) begin
          pt_valid <= 1'b0;
        end else begin
          nxt = point_q.pop_front();
          pt_x     <= nxt.x;
          pt_y     <= nxt.y;
          pt_fin   <= nxt.fin;
          pt_valid <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: random stall bursts and one long hold-off
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  int  hold_left = 0;
  bit  held_long = 1'b0;
  int  recv_mood = 0;
  int  recv_mood_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      cv_ready <= 1'b0;
    end else begin
      if (!held_long && samples_taken >= HOLD_AFTER) begin
        held_long = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (recv_mood_left == 0) begin
        recv_mood = $urandom_range(0, 2);
        recv_mood_left = $urandom_range(50, 300);
      end else begin
        recv_mood_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        cv_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        cv_ready <= 1'b0;
      end else if (point_q.size() > CALM_PTS && recv_mood != 0 &&
                   $urandom_range(0, 15) < recv_mood) begin
        stall_left = $urandom_range(0, 9);
        cv_ready <= 1'b0;
      end else begin
        cv_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken sample with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && cv_ch.valid && cv_ready) begin
      samples_taken <= samples_taken + 1;
      if (curve_q.size() == 0) begin
        $display("%0t: unexpected sample x=%0d y=%0d run_end=%0b", $time,
                 cv_ch.curve_x, cv_ch.curve_y, cv_ch.run_end);
        mismatches++;
      end else begin
        want = curve_q.pop_front();
        if (cv_ch.curve_x !== want.x) begin
          $display("%0t: curve_x expected %0d actual %0d", $time, want.x, cv_ch.curve_x);
          mismatches++;
        end
        if (cv_ch.curve_y !== want.y) begin
          $display("%0t: curve_y expected %0d actual %0d", $time, want.y, cv_ch.curve_y);
          mismatches++;
        end
        if (cv_ch.run_end !== want.run_end) begin
          $display("%0t: run_end expected %0b actual %0b", $time, want.run_end,
                   cv_ch.run_end);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("hermite_polyline_smoother test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: weights, stimulus, reset, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    longint n3;
    int     sent;
    int     len;
    int     style;
    int     px;
    int     py;
    int     line_no;

    // basis weights in Q2.16
    n3 = longint'(SAMPLES) * SAMPLES * SAMPLES;
    for (longint t = 0; t < SAMPLES; t++) begin
      basis[t][0] = q16_div(2 * t * t * t - 3 * t * t * SAMPLES + n3, n3);
      basis[t][1] = q16_div(-2 * t * t * t + 3 * t * t * SAMPLES, n3);
      basis[t][2] = q16_div(t * t * t - 2 * t * t * SAMPLES + t * SAMPLES * SAMPLES, n3);
      basis[t][3] = q16_div(t * t * t - t * t * SAMPLES, n3);
    end
    for (int i = 0; i < 3; i++) begin
      hist_x[i] = 0;
      hist_y[i] = 0;
    end

    // single-point polyline: no samples
    add_point(100, -200, 1, 0);
    // two-point polyline at the range corners
    add_point(-32768, 32767, 0, 0);
    add_point(32767, -32768, 1, 0);
    // three-point polyline, sent after everything has drained
    add_point(0, 0, 0, 1);
    add_point(1000, 500, 0, 0);
    add_point(-1000, 2000, 1, 0);
    // extreme swings for the largest tangents
    add_point(32767, 32767, 0, 0);
    add_point(-32768, -32768, 0, 0);
    add_point(32767, -32768, 0, 0);
    add_point(-32768, 32767, 0, 0);
    add_point(0, 0, 1, 0);
    // all-ones and small values
    add_point(-1, 0, 0, 0);
    add_point(0, -1, 0, 0);
    add_point(12345, -12345, 0, 0);
    add_point(-1, -1, 1, 0);
    // single point again right after a closing point
    add_point(-32768, -32768, 1, 0);

    // random polylines, mostly of useful length
    sent = 0;
    line_no = 0;
    while (sent < RANDOM_PTS) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = 2;
        default: len = $urandom_range(3, 12);
      endcase
      style = $urandom_range(0, 5);
      style = (style < 2) ? 0 : (style < 5) ? 1 : 2;
      px = $urandom_range(0, 65535) - 32768;
      py = $urandom_range(0, 65535) - 32768;
      for (int k = 0; k < len; k++) begin
        px = pick_coord(style, px);
        py = pick_coord(style, py);
        add_point(px, py, k == len - 1, k == 0 && line_no == 4);
      end
      sent += len;
      line_no++;
    end

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;

    while (point_q.size() != 0 || pt_valid)
      @(posedge clk);
    while (curve_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (mismatches == 0 && curve_q.size() == 0)
      $display("hermite_polyline_smoother test passed");
    else
      $display("hermite_polyline_smoother test failed");
    $finish;
  end

endmodule

`default_nettype wire
